FILE: rtl/core/ksq_pkg.sv
// Shared constants, microcode encoding and control-word types for the
// quickselect block. Used by every module of the block except the generic RAM.
package ksq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int TGT_W  = 10;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int IDX_W  = ADDR_W + 2;
    localparam int PC_W   = 4;
    localparam int COND_W = 4;
    localparam int ASEL_W = 2;

    localparam logic [1:0] REG_TARGET = 2'd0;

    localparam logic [COND_W-1:0] C_NEVER   = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS  = 4'd1;
    localparam logic [COND_W-1:0] C_NOT_LR  = 4'd2;
    localparam logic [COND_W-1:0] C_I_GT_J  = 4'd3;
    localparam logic [COND_W-1:0] C_I_GT_R  = 4'd4;
    localparam logic [COND_W-1:0] C_J_LT_L  = 4'd5;
    localparam logic [COND_W-1:0] C_RD_LT_X = 4'd6;
    localparam logic [COND_W-1:0] C_RD_GT_X = 4'd7;
    localparam logic [COND_W-1:0] C_K_LE_J  = 4'd8;
    localparam logic [COND_W-1:0] C_K_GE_I  = 4'd9;

    localparam logic [ASEL_W-1:0] A_MID = 2'd0;
    localparam logic [ASEL_W-1:0] A_I   = 2'd1;
    localparam logic [ASEL_W-1:0] A_J   = 2'd2;
    localparam logic [ASEL_W-1:0] A_K   = 2'd3;

    localparam logic [PC_W-1:0] S_INIT  = 4'd0;
    localparam logic [PC_W-1:0] S_OUTER = 4'd1;
    localparam logic [PC_W-1:0] S_LDX   = 4'd2;
    localparam logic [PC_W-1:0] S_LOOP  = 4'd3;
    localparam logic [PC_W-1:0] S_RDI   = 4'd4;
    localparam logic [PC_W-1:0] S_CHKI  = 4'd5;
    localparam logic [PC_W-1:0] S_RDJ   = 4'd6;
    localparam logic [PC_W-1:0] S_CHKJ  = 4'd7;
    localparam logic [PC_W-1:0] S_TSW   = 4'd8;
    localparam logic [PC_W-1:0] S_WRI   = 4'd9;
    localparam logic [PC_W-1:0] S_WRJ   = 4'd10;
    localparam logic [PC_W-1:0] S_PEND1 = 4'd11;
    localparam logic [PC_W-1:0] S_PEND2 = 4'd12;
    localparam logic [PC_W-1:0] S_DONE  = 4'd13;
    localparam logic [PC_W-1:0] S_EMIT  = 4'd14;

    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic [ASEL_W-1:0] asel;
        logic              init_lr;
        logic              ld_ij;
        logic              ld_x;
        logic              ld_vi;
        logic              ld_vj;
        logic              wr_i;
        logic              wr_j;
        logic              inc_i;
        logic              dec_j;
        logic              r_from_j;
        logic              l_from_i;
        logic              emit;
    } ksq_uword_t;

    typedef struct packed {
        ksq_uword_t w;
        logic       take;
        logic       run;
    } ksq_ctrl_t;

    typedef struct packed {
        logic lr_ge;
        logic i_gt_j;
        logic i_gt_r;
        logic j_lt_l;
        logic rd_lt_x;
        logic rd_gt_x;
        logic k_le_j;
        logic k_ge_i;
    } ksq_flags_t;

    function automatic ksq_uword_t ucode(input logic [PC_W-1:0] pc);
        ksq_uword_t w;
        w = '0;
        case (pc)
            S_INIT:  w.init_lr = 1'b1;
            S_OUTER:
            begin
                w.cond   = C_NOT_LR;
                w.target = S_DONE;
                w.asel   = A_MID;
                w.ld_ij  = 1'b1;
            end
            S_LDX:   w.ld_x = 1'b1;
            S_LOOP:
            begin
                w.cond   = C_I_GT_J;
                w.target = S_PEND1;
            end
            S_RDI:
            begin
                w.cond   = C_I_GT_R;
                w.target = S_RDJ;
                w.asel   = A_I;
            end
            S_CHKI:
            begin
                w.cond   = C_RD_LT_X;
                w.target = S_RDI;
                w.inc_i  = 1'b1;
                w.ld_vi  = 1'b1;
            end
            S_RDJ:
            begin
                w.cond   = C_J_LT_L;
                w.target = S_TSW;
                w.asel   = A_J;
            end
            S_CHKJ:
            begin
                w.cond   = C_RD_GT_X;
                w.target = S_RDJ;
                w.dec_j  = 1'b1;
                w.ld_vj  = 1'b1;
            end
            S_TSW:
            begin
                w.cond   = C_I_GT_J;
                w.target = S_LOOP;
            end
            S_WRI:   w.wr_i = 1'b1;
            S_WRJ:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_LOOP;
                w.wr_j   = 1'b1;
                w.inc_i  = 1'b1;
                w.dec_j  = 1'b1;
            end
            S_PEND1:
            begin
                w.cond     = C_K_LE_J;
                w.target   = S_OUTER;
                w.r_from_j = 1'b1;
            end
            S_PEND2:
            begin
                w.cond     = C_K_GE_I;
                w.target   = S_OUTER;
                w.l_from_i = 1'b1;
            end
            S_DONE:  w.asel = A_K;
            S_EMIT:  w.emit = 1'b1;
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/ksq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module ksq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ksq_useq.sv
// Microcode sequencer: step counter, control ROM and jump condition select.
// Depends on ksq_pkg for the microcode table and control types.
module ksq_useq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ksq_pkg::ksq_flags_t flags,
    output ksq_pkg::ksq_ctrl_t  ctrl,
    output logic               done
);
    import ksq_pkg::*;

    logic            run_reg, run_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ksq_uword_t      w;
    logic            take;

    assign w = ucode(pc_reg);

    always_comb
    begin
        case (w.cond)
            C_NEVER:   take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_NOT_LR:  take = flags.lr_ge;
            C_I_GT_J:  take = flags.i_gt_j;
            C_I_GT_R:  take = flags.i_gt_r;
            C_J_LT_L:  take = flags.j_lt_l;
            C_RD_LT_X: take = flags.rd_lt_x;
            C_RD_GT_X: take = flags.rd_gt_x;
            C_K_LE_J:  take = flags.k_le_j;
            C_K_GE_I:  take = flags.k_ge_i;
            default:   take = 1'b0;
        endcase
    end

    always_comb
    begin
        run_next = run_reg;
        pc_next  = pc_reg;
        if (run_reg)
        begin
            pc_next = take ? w.target : pc_reg + 1'b1;
            if (w.emit)
            begin
                run_next = 1'b0;
            end
        end
        else if (start)
        begin
            run_next = 1'b1;
            pc_next  = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= S_INIT;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
        end
    end

    assign ctrl.w    = w;
    assign ctrl.take = take;
    assign ctrl.run  = run_reg;
    assign done      = run_reg & w.emit;

endmodule

FILE: rtl/core/ksq_dpath.sv
// Partition datapath: bound and scan index registers, pivot and swap holds,
// RAM address and write selection, and the compare flags for the sequencer.
// Depends on ksq_pkg.
module ksq_dpath (
    input  logic                       clk,
    input  ksq_pkg::ksq_ctrl_t         ctrl,
    input  logic [ksq_pkg::CNT_W-1:0]  count,
    input  logic [ksq_pkg::ADDR_W-1:0] k,
    input  logic [ksq_pkg::DATA_W-1:0] rdata,
    output ksq_pkg::ksq_flags_t        flags,
    output logic [ksq_pkg::ADDR_W-1:0] raddr,
    output logic                       we,
    output logic [ksq_pkg::ADDR_W-1:0] waddr,
    output logic [ksq_pkg::DATA_W-1:0] wdata
);
    import ksq_pkg::*;

    logic signed [IDX_W-1:0]  l_reg, l_next;
    logic signed [IDX_W-1:0]  r_reg, r_next;
    logic signed [IDX_W-1:0]  i_reg, i_next;
    logic signed [IDX_W-1:0]  j_reg, j_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0]        vi_reg, vi_next;
    logic [DATA_W-1:0]        vj_reg, vj_next;
    logic [IDX_W:0]           sum;
    logic [ADDR_W-1:0]        mid;
    logic signed [IDX_W-1:0]  k_s;
    logic signed [DATA_W-1:0] rd_s;
    ksq_uword_t               w;
    logic                     take;

    assign w    = ctrl.w;
    assign take = ctrl.take;
    assign sum  = {l_reg[IDX_W-1], l_reg} + {r_reg[IDX_W-1], r_reg};
    assign mid  = sum[ADDR_W:1];
    assign k_s  = signed'(IDX_W'(k));
    assign rd_s = signed'(rdata);

    always_comb
    begin
        flags.lr_ge   = l_reg >= r_reg;
        flags.i_gt_j  = i_reg > j_reg;
        flags.i_gt_r  = i_reg > r_reg;
        flags.j_lt_l  = j_reg < l_reg;
        flags.rd_lt_x = rd_s < x_reg;
        flags.rd_gt_x = rd_s > x_reg;
        flags.k_le_j  = k_s <= j_reg;
        flags.k_ge_i  = k_s >= i_reg;
    end

    always_comb
    begin
        case (w.asel)
            A_MID:   raddr = mid;
            A_I:     raddr = i_reg[ADDR_W-1:0];
            A_J:     raddr = j_reg[ADDR_W-1:0];
            A_K:     raddr = k;
            default: raddr = k;
        endcase
    end

    assign we    = ctrl.run & (w.wr_i | w.wr_j);
    assign waddr = w.wr_i ? i_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0];
    assign wdata = w.wr_i ? vj_reg : vi_reg;

    always_comb
    begin
        l_next  = l_reg;
        r_next  = r_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        x_next  = x_reg;
        vi_next = vi_reg;
        vj_next = vj_reg;
        if (ctrl.run)
        begin
            if (w.init_lr)
            begin
                l_next = '0;
                r_next = signed'(IDX_W'(count)) - IDX_W'(1);
            end
            if (w.ld_ij)
            begin
                i_next = l_reg;
                j_next = r_reg;
            end
            if (w.ld_x)
            begin
                x_next = rd_s;
            end
            if (w.ld_vi)
            begin
                vi_next = rdata;
            end
            if (w.ld_vj)
            begin
                vj_next = rdata;
            end
            if (take && w.inc_i)
            begin
                i_next = i_reg + IDX_W'(1);
            end
            if (take && w.dec_j)
            begin
                j_next = j_reg - IDX_W'(1);
            end
            if (take && w.r_from_j)
            begin
                r_next = j_reg;
            end
            if (take && w.l_from_i)
            begin
                l_next = i_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg  <= l_next;
        r_reg  <= r_next;
        i_reg  <= i_next;
        j_reg  <= j_next;
        x_reg  <= x_next;
        vi_reg <= vi_next;
        vj_reg <= vj_next;
    end

endmodule

FILE: rtl/core/kth_smallest_quickselect.sv
// Top level of the k-th smallest selector: load control, configuration port,
// result register, and the RAM, sequencer and datapath instances. Uses ksq_pkg.
//
// Values are loaded one per cycle while in_stall is low into a single-port-write,
// registered-read RAM. The item flagged last starts a microcoded Hoare-partition
// quickselect over the stored set, with the input stalled until the selection
// ends. Each scan step of either index is a RAM read and then a compare; each
// round of the inner loop adds its check, the two stopping reads and the swap
// test, and a swap adds the two writes; each partition pass adds the pivot
// fetch, the closing check and the bound update, whose second check is skipped
// when the rank falls left. The result is read from the RAM at the rank, with
// the word in the result register the cycle after the emit step; the selection
// is bounded by the one RAM read port. An out-of-range rank or a
// dropped item gives an error result the cycle after the last item, with no
// selection run.
module kth_smallest_quickselect (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [31:0]         sample_value,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         selected_value,
    output logic                       error_flag
);
    import ksq_pkg::*;

    localparam int CMP_W = ((TGT_W > CNT_W) ? TGT_W : CNT_W) + 1;

    logic [TGT_W-1:0]  target_reg, target_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              err_reg, err_next;

    logic              in_acc;
    logic              room;
    logic [CNT_W-1:0]  count_after;
    logic              err_now;
    logic              start;
    logic              seq_done;
    ksq_ctrl_t         ctrl;
    ksq_flags_t        flags;
    logic [ADDR_W-1:0] raddr;
    logic              seq_we;
    logic [ADDR_W-1:0] seq_waddr;
    logic [DATA_W-1:0] seq_wdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TARGET) ? 32'(target_reg) : '0;

    assign in_stall    = ctrl.run | (out_valid_reg & out_stall);
    assign in_acc      = in_valid & ~in_stall;
    assign room        = count_reg < CNT_W'(DEPTH);
    assign count_after = room ? count_reg + 1'b1 : count_reg;
    assign err_now     = ovf_reg | ~room | (CMP_W'(target_reg) >= CMP_W'(count_after));
    assign start       = in_acc & last_item & ~err_now;

    assign ram_we    = ctrl.run ? seq_we : (in_acc & room);
    assign ram_waddr = ctrl.run ? seq_waddr : count_reg[ADDR_W-1:0];
    assign ram_wdata = ctrl.run ? seq_wdata : sample_value;

    always_comb
    begin
        target_next    = target_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        err_next       = err_reg;
        if (psel && penable && pwrite && pready)
        begin
            target_next = pwdata[TGT_W-1:0];
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (in_acc)
        begin
            count_next = count_after;
            ovf_next   = ovf_reg | ~room;
            if (last_item)
            begin
                ovf_next = 1'b0;
                k_next   = ADDR_W'(target_reg);
                if (err_now)
                begin
                    count_next     = '0;
                    out_valid_next = 1'b1;
                    value_next     = '0;
                    err_next       = 1'b1;
                end
            end
        end
        if (seq_done)
        begin
            count_next     = '0;
            out_valid_next = 1'b1;
            value_next     = rdata;
            err_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        value_reg <= value_next;
        err_reg   <= err_next;
    end

    assign out_valid      = out_valid_reg;
    assign selected_value = signed'(value_reg);
    assign error_flag     = err_reg;

    ksq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ksq_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctrl  (ctrl),
        .done  (seq_done)
    );

    ksq_dpath u_dpath (
        .clk   (clk),
        .ctrl  (ctrl),
        .count (count_reg),
        .k     (k_reg),
        .rdata (rdata),
        .flags (flags),
        .raddr (raddr),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> value_reg == '0)
        else $error("error result carries a nonzero value");

    a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.run |-> in_stall)
        else $error("input taken while selection runs");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> !out_valid_reg)
        else $error("selection finished onto an occupied result register");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ctrl.run && !out_valid_reg)
        else $error("last item did not start the selection");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond store depth");

endmodule
